### rtl/video_test_card_pixel_assert.svh
// Assertion macros used by the test card divider cell.
// Depends on nothing; files that assert include it by name.
`ifndef VIDEO_TEST_CARD_PIXEL_ASSERT_SVH
`define VIDEO_TEST_CARD_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define VTC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define VTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/vtc_pkg.sv
// Shared types, field widths, region codes and colors for the test card block.
// No dependencies; every RTL module imports it.
`default_nettype none

package vtc_pkg;

    // Field and register widths
    localparam int PIX_X_W  = 11;
    localparam int PIX_Y_W  = 12;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int ARGB_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Reset values and default width limit
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int MAX_WIDTH_DEF = 1920;

    // Card geometry
    localparam int EDGE_BORDER = 8;
    localparam int EDGE_CORNER = 64;

    // Divider lanes: grey = x*255/w (bit 8 flags saturation), bar = x*8/w (bit 3 flags it)
    localparam int GREY_TOP  = 8;
    localparam int BAR_TOP   = 3;
    localparam int GREY_Q_W  = GREY_TOP + 1;
    localparam int BAR_Q_W   = BAR_TOP + 1;
    localparam int GREY_N_W  = PIX_X_W + GREY_TOP;
    localparam int BAR_N_W   = PIX_X_W + BAR_TOP;
    localparam int NUM_CELLS = GREY_TOP + 1;

    // Region codes
    localparam int CLS_W = 3;
    localparam logic [CLS_W-1:0] CLS_WHITE = 3'd0;
    localparam logic [CLS_W-1:0] CLS_RED   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_GREEN = 3'd2;
    localparam logic [CLS_W-1:0] CLS_BLUE  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_RAMP  = 3'd4;
    localparam logic [CLS_W-1:0] CLS_BARS  = 3'd5;

    // Colors
    localparam logic [ARGB_W-1:0] ARGB_WHITE   = 32'hFFFF_FFFF;
    localparam logic [ARGB_W-1:0] ARGB_YELLOW  = 32'hFFFF_FF00;
    localparam logic [ARGB_W-1:0] ARGB_CYAN    = 32'hFF00_FFFF;
    localparam logic [ARGB_W-1:0] ARGB_GREEN   = 32'hFF00_FF00;
    localparam logic [ARGB_W-1:0] ARGB_MAGENTA = 32'hFFFF_00FF;
    localparam logic [ARGB_W-1:0] ARGB_RED     = 32'hFFFF_0000;
    localparam logic [ARGB_W-1:0] ARGB_BLUE    = 32'hFF00_00FF;
    localparam logic [ARGB_W-1:0] ARGB_OPAQUE  = 32'hFF00_0000;
    localparam logic [7:0]        GREY_MAX     = 8'hFF;
    localparam logic [2:0]        BAR_LAST     = 3'd7;

    // One item as it travels down the divider chain
    typedef struct packed {
        logic [CLS_W-1:0]    cls;
        logic [GREY_N_W-1:0] grey_rem;
        logic [BAR_N_W-1:0]  bar_rem;
        logic [GREY_Q_W-1:0] grey_q;
        logic [BAR_Q_W-1:0]  bar_q;
    } vtc_item_t;

    // Vertical bar colors, left to right
    function automatic logic [ARGB_W-1:0] bar_colour(input logic [2:0] idx);
        logic [ARGB_W-1:0] c;
        case (idx)
            3'd0:    c = ARGB_WHITE;
            3'd1:    c = ARGB_YELLOW;
            3'd2:    c = ARGB_CYAN;
            3'd3:    c = ARGB_GREEN;
            3'd4:    c = ARGB_MAGENTA;
            3'd5:    c = ARGB_RED;
            3'd6:    c = ARGB_BLUE;
            default: c = ARGB_OPAQUE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/vtc_front.sv
// Input stage: classifies a pixel into its card region and forms the dividends.
// Depends on vtc_pkg.
`default_nettype none

module vtc_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [vtc_pkg::WIDTH_W-1:0]  width,
    input  wire logic [vtc_pkg::HEIGHT_W-1:0] height,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [vtc_pkg::PIX_X_W-1:0]  pixel_x,
    input  wire logic [vtc_pkg::PIX_Y_W-1:0]  pixel_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output vtc_pkg::vtc_item_t                out_item
);
    import vtc_pkg::*;

    localparam int XE_W = PIX_X_W + 1;
    localparam int YE_W = PIX_Y_W + 1;

    logic                 valid_reg;
    vtc_item_t            item_reg;
    vtc_item_t            item_next;
    logic [XE_W-1:0]      x_ext;
    logic [YE_W-1:0]      y_ext;
    logic [XE_W-1:0]      w_ext;
    logic [YE_W-1:0]      h_ext;
    logic                 in_border;
    logic                 near_top;
    logic                 near_left;
    logic                 near_bottom;
    logic                 near_right;
    logic [HEIGHT_W-1:0]  h_half;
    logic [HEIGHT_W+1:0]  h_three;
    logic [HEIGHT_W-1:0]  h_three_q;
    logic                 in_ramp;

    // Widen so the signed edge tests become plain unsigned ones
    assign x_ext = XE_W'(pixel_x);
    assign y_ext = YE_W'(pixel_y);
    assign w_ext = XE_W'(width);
    assign h_ext = YE_W'(height);

    assign in_border = (y_ext < YE_W'(EDGE_BORDER))
                    || (y_ext + YE_W'(EDGE_BORDER) >= h_ext)
                    || (x_ext < XE_W'(EDGE_BORDER))
                    || (x_ext + XE_W'(EDGE_BORDER) >= w_ext);
    assign near_top    = y_ext < YE_W'(EDGE_CORNER);
    assign near_left   = x_ext < XE_W'(EDGE_CORNER);
    assign near_bottom = y_ext + YE_W'(EDGE_CORNER) >= h_ext;
    assign near_right  = x_ext + XE_W'(EDGE_CORNER) >= w_ext;

    // Ramp rows: from h/2 up to, not including, 3h/4
    assign h_half    = height >> 1;
    assign h_three   = (HEIGHT_W+2)'(height) + ((HEIGHT_W+2)'(height) << 1);
    assign h_three_q = h_three[HEIGHT_W+1:2];
    assign in_ramp   = (YE_W'(pixel_y) >= YE_W'(h_half)) && (YE_W'(pixel_y) < YE_W'(h_three_q));

    // Pick the region in priority order and load the divider lanes
    always_comb begin
        item_next = '0;
        if (in_border) begin
            item_next.cls = CLS_WHITE;
        end else if (near_top && near_left) begin
            item_next.cls = CLS_RED;
        end else if (near_top && near_right) begin
            item_next.cls = CLS_GREEN;
        end else if (near_bottom && near_left) begin
            item_next.cls = CLS_BLUE;
        end else if (near_bottom && near_right) begin
            item_next.cls = CLS_WHITE;
        end else if (in_ramp) begin
            item_next.cls = CLS_RAMP;
        end else begin
            item_next.cls = CLS_BARS;
        end
        item_next.grey_rem = (GREY_N_W'(pixel_x) << GREY_TOP) - GREY_N_W'(pixel_x);
        item_next.bar_rem  = BAR_N_W'(pixel_x) << BAR_TOP;
    end

    // Advance when the slot is empty or drains this cycle
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

### rtl/vtc_div_cell.sv
// Divider chain cell: compare-and-subtract on grey; on bar if SHIFT <= 3.
// Depends on vtc_pkg and video_test_card_pixel_assert.svh.
`default_nettype none
`include "video_test_card_pixel_assert.svh"

module vtc_div_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [vtc_pkg::WIDTH_W-1:0] width,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire vtc_pkg::vtc_item_t          in_item,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output vtc_pkg::vtc_item_t               out_item
);
    import vtc_pkg::*;

    localparam logic [GREY_Q_W-1:0] LOW_MASK = GREY_Q_W'((1 << SHIFT) - 1);
    localparam logic                BAR_STEP = (SHIFT <= BAR_TOP);

    logic                valid_reg;
    vtc_item_t           item_reg;
    vtc_item_t           item_next;
    logic [GREY_N_W:0]   grey_div;
    logic [BAR_N_W:0]    bar_div;
    logic                grey_geq;
    logic                bar_geq;
    logic                rem_bound_ok;

    // Divisor scaled to this cell's quotient bit
    assign grey_div = (GREY_N_W+1)'(width) << SHIFT;
    assign bar_div  = (BAR_N_W+1)'(width) << SHIFT;
    assign grey_geq = (GREY_N_W+1)'(in_item.grey_rem) >= grey_div;
    assign bar_geq  = BAR_STEP && ((BAR_N_W+1)'(in_item.bar_rem) >= bar_div);

    // Subtract where it fits and record the quotient bit
    always_comb begin
        item_next = in_item;
        if (grey_geq) begin
            item_next.grey_rem = in_item.grey_rem - grey_div[GREY_N_W-1:0];
        end
        if (bar_geq) begin
            item_next.bar_rem = in_item.bar_rem - bar_div[BAR_N_W-1:0];
        end
        item_next.grey_q = in_item.grey_q | (GREY_Q_W'(grey_geq) << SHIFT);
        item_next.bar_q  = in_item.bar_q | (BAR_Q_W'(bar_geq) << SHIFT);
    end

    // Take a new transfer when empty or when the held one moves on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Unsaturated items keep a remainder below the divisor of this step
    assign rem_bound_ok = (GREY_N_W+1)'(item_reg.grey_rem) < grey_div;

    `VTC_ASSERT_IMPL(a_grey_rem_bound, aclk, aresetn, out_valid && !item_reg.grey_q[GREY_TOP], rem_bound_ok, "grey remainder not reduced")
    `VTC_ASSERT_IMPL(a_low_bits_clear, aclk, aresetn, out_valid, (item_reg.grey_q & LOW_MASK) == '0, "quotient bit set ahead of its cell")
    `VTC_ASSERT_NEXT(a_drain_empties, aclk, aresetn, out_valid && out_ready && !in_valid, !out_valid, "cell kept a drained item")

endmodule

`default_nettype wire

### rtl/video_test_card_pixel.sv
// Top level of the test card pixel generator: config registers, input stage,
// divider chain and color mapping. Depends on vtc_pkg, vtc_front, vtc_div_cell.
`default_nettype none

// Maps each (pixel_x, pixel_y) transfer to a 32-bit ARGB test card color for the
// configured frame size: white border, colored corner squares, a grey ramp band
// and eight color bars. Each pixel passes one classification stage followed by
// a chain of nine divider cells, each resolving one bit of x*255/width (the
// last four also one bit of x*8/width). One pixel is accepted per clock and
// throughput stays at one pixel per clock while the output is taken; a stalled
// output fills the chain before s_ready drops. frame_width is clamped to
// MAX_WIDTH when written. Write the config registers only while no pixel is in
// flight.
module video_test_card_pixel #(
    parameter int MAX_WIDTH = vtc_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [vtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vtc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [vtc_pkg::PIX_X_W-1:0]    s_pixel_x,
    input  wire logic [vtc_pkg::PIX_Y_W-1:0]    s_pixel_y,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [vtc_pkg::ARGB_W-1:0]          m_pixel_argb
);
    import vtc_pkg::*;

    localparam int WIDTH_FULL  = (1 << WIDTH_W) - 1;
    localparam int WIDTH_CLAMP = (MAX_WIDTH > WIDTH_FULL) ? WIDTH_FULL : MAX_WIDTH;
    localparam int WIDTH_INIT  = (WIDTH_RESET > WIDTH_CLAMP) ? WIDTH_CLAMP : WIDTH_RESET;

    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic [WIDTH_W-1:0]  width_wr;

    logic [NUM_CELLS:0]  link_valid;
    logic [NUM_CELLS:0]  link_ready;
    vtc_item_t           link_item [NUM_CELLS+1];

    vtc_item_t           last_item;
    logic [7:0]          grey;
    logic [2:0]          bar_idx;

    // Clamp the width as it is written
    assign width_wr = (cfg_wr_data[WIDTH_W-1:0] > WIDTH_W'(WIDTH_CLAMP))
                    ? WIDTH_W'(WIDTH_CLAMP) : cfg_wr_data[WIDTH_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_W'(WIDTH_INIT);
            frame_height_reg <= HEIGHT_W'(HEIGHT_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= width_wr;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify and form dividends
    vtc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .width     (frame_width_reg),
        .height    (frame_height_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .pixel_x   (s_pixel_x),
        .pixel_y   (s_pixel_y),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_item  (link_item[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        vtc_div_cell #(
            .SHIFT (GREY_TOP - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .width     (frame_width_reg),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_item   (link_item[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_item  (link_item[i+1])
        );
    end

    assign m_valid              = link_valid[NUM_CELLS];
    assign link_ready[NUM_CELLS] = m_ready;
    assign last_item            = link_item[NUM_CELLS];

    // Saturate the quotients
    assign grey    = last_item.grey_q[GREY_TOP] ? GREY_MAX : last_item.grey_q[7:0];
    assign bar_idx = last_item.bar_q[BAR_TOP] ? BAR_LAST : last_item.bar_q[2:0];

    // Map the region to its color
    always_comb begin
        case (last_item.cls)
            CLS_WHITE: m_pixel_argb = ARGB_WHITE;
            CLS_RED:   m_pixel_argb = ARGB_RED;
            CLS_GREEN: m_pixel_argb = ARGB_GREEN;
            CLS_BLUE:  m_pixel_argb = ARGB_BLUE;
            CLS_RAMP:  m_pixel_argb = ARGB_OPAQUE | {8'h00, grey, grey, grey};
            CLS_BARS:  m_pixel_argb = bar_colour(bar_idx);
            default:   m_pixel_argb = ARGB_WHITE;
        endcase
    end

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the test card pixel generator: drives pixel
// coordinates across several frame sizes and checks every ARGB color.
// Depends on vtc_pkg and video_test_card_pixel.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vtc_pkg::*;

    typedef struct packed {
        logic [PIX_X_W-1:0] x;
        logic [PIX_Y_W-1:0] y;
    } pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PIX_X_W-1:0]    s_pixel_x = '0;
    logic [PIX_Y_W-1:0]    s_pixel_y = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ARGB_W-1:0]     m_pixel_argb;

    // Frame size as written; card_argb and add_pixels clamp the width to MAX_WIDTH_DEF
    logic [WIDTH_W-1:0]  frame_w = WIDTH_W'(WIDTH_RESET);
    logic [HEIGHT_W-1:0] frame_h = HEIGHT_W'(HEIGHT_RESET);

    pixel_t            pixel_q[$];
    logic [ARGB_W-1:0] argb_expected[$];
    pixel_t            next_pixel;
    int                burst_left = 1;
    int                gap_left = 0;
    int                stall_mode = 0;
    int                stall_count = 0;
    int                pixels_checked = 0;
    int                frame_sizes = 0;
    int                errors = 0;

    video_test_card_pixel dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_x    (s_pixel_x),
        .s_pixel_y    (s_pixel_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_argb (m_pixel_argb)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Color of one pixel for the current frame size; edges compare signed
    function automatic logic [ARGB_W-1:0] card_argb(input logic [PIX_X_W-1:0] px,
                                                    input logic [PIX_Y_W-1:0] py);
        int          x, y, w, h;
        int unsigned grey, bar;
        logic [7:0]  g;
        x = int'(px);
        y = int'(py);
        w = (int'(frame_w) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(frame_w);
        h = int'(frame_h);
        if (y < EDGE_BORDER || y >= h - EDGE_BORDER ||
            x < EDGE_BORDER || x >= w - EDGE_BORDER)
            return ARGB_WHITE;
        if (y < EDGE_CORNER && x < EDGE_CORNER)
            return ARGB_RED;
        if (y < EDGE_CORNER && x >= w - EDGE_CORNER)
            return ARGB_GREEN;
        if (y >= h - EDGE_CORNER && x < EDGE_CORNER)
            return ARGB_BLUE;
        if (y >= h - EDGE_CORNER && x >= w - EDGE_CORNER)
            return ARGB_WHITE;
        if (y >= h / 2 && y < (3 * h) / 4) begin
            grey = (x * 255) / w;
            g = (grey > 255) ? 8'hFF : grey[7:0];
            return ARGB_OPAQUE | {8'h00, g, g, g};
        end
        bar = (x * 8) / w;
        case ((bar > 7) ? 7 : bar)
            0:       return ARGB_WHITE;
            1:       return ARGB_YELLOW;
            2:       return ARGB_CYAN;
            3:       return ARGB_GREEN;
            4:       return ARGB_MAGENTA;
            5:       return ARGB_RED;
            6:       return ARGB_BLUE;
            default: return ARGB_OPAQUE;
        endcase
    endfunction

    // Driver: record each accepted transfer, then present the next pixel or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                argb_expected.push_back(card_argb(s_pixel_x, s_pixel_y));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    next_pixel = pixel_q.pop_front();
                    s_valid   <= 1'b1;
                    s_pixel_x <= next_pixel.x;
                    s_pixel_y <= next_pixel.y;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the output on a changing pattern and check every transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (argb_expected.size() == 0) begin
                    $display("%0t: unexpected pixel, actual %h", $realtime, m_pixel_argb);
                    errors++;
                end else begin
                    if (m_pixel_argb !== argb_expected[0]) begin
                        $display("%0t: pixel_argb mismatch, expected %h actual %h",
                                 $realtime, argb_expected[0], m_pixel_argb);
                        errors++;
                    end
                    void'(argb_expected.pop_front());
                    pixels_checked++;
                end
            end
            stall_count++;
            if (stall_count >= 50) begin
                stall_count = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (stall_count % 3 != 0);
            endcase
        end
    end

    // Wait until no pixel is queued, offered or in flight
    task automatic wait_idle();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || argb_expected.size() != 0 || s_valid);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        if (idx == REG_FRAME_WIDTH)
            frame_w = data[WIDTH_W-1:0];
        else
            frame_h = data[HEIGHT_W-1:0];
    endtask

    // Change the frame size between runs of pixels
    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        frame_sizes++;
    endtask

    task automatic add_pixel(input int x, input int y);
        pixel_t p;
        p.x = PIX_X_W'(x);
        p.y = PIX_Y_W'(y);
        pixel_q.push_back(p);
    endtask

    // Frame edges, corners and centre of the current size, a far pixel, then random pixels
    task automatic add_pixels(input int count);
        int w, h;
        w = (int'(frame_w) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(frame_w);
        h = int'(frame_h);
        add_pixel(0, 0);
        add_pixel(EDGE_BORDER, EDGE_BORDER);
        add_pixel((w > 9) ? w - 9 : 0, EDGE_BORDER);
        add_pixel(EDGE_BORDER, (h > 9) ? h - 9 : 0);
        add_pixel((w > 9) ? w - 9 : 0, (h > 9) ? h - 9 : 0);
        add_pixel(w / 2, h / 2);
        add_pixel(2047, 4095);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0 || w == 0 || h == 0)
                add_pixel($urandom_range(0, 2047), $urandom_range(0, 4095));
            else
                add_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        frame_sizes = 1;

        // Reset size 640x480: border, corner squares, ramp rows, every bar
        add_pixel(0, 0);
        add_pixel(7, 100);
        add_pixel(632, 200);
        add_pixel(300, 472);
        add_pixel(2047, 4095);
        add_pixel(8, 8);
        add_pixel(63, 63);
        add_pixel(576, 8);
        add_pixel(575, 8);
        add_pixel(8, 416);
        add_pixel(8, 471);
        add_pixel(631, 471);
        add_pixel(100, 240);
        add_pixel(631, 359);
        add_pixel(100, 360);
        add_pixel(64, 239);
        for (int k = 0; k < 8; k++)
            add_pixel(80 * k + 10, 100);
        add_pixels(300);

        set_frame(1920, 1080);
        add_pixels(400);
        // Width beyond the limit, extra data bit set: clamps to the maximum
        set_frame(12'hFFF, 4095);
        add_pixels(200);
        set_frame(0, 0);
        add_pixels(50);
        set_frame(1, 1);
        add_pixels(50);
        set_frame(64, 64);
        add_pixels(100);
        set_frame(17, 4095);
        add_pixels(100);
        repeat (4) begin
            set_frame(CFG_DATA_W'($urandom_range(1, 2047)),
                      CFG_DATA_W'($urandom_range(1, 4095)));
            add_pixels(200);
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("testbench: %0d pixels checked across %0d frame sizes",
                 pixels_checked, frame_sizes);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
